FILE: rtl/core/semc_pkg.sv
// Shared types and constants for the supply enable mode controller.
package semc_pkg;

    localparam int unsigned CNT_W       = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 8;

    localparam logic [CNT_W-1:0] HALF_PERIOD_RESET = 8'd10;
    localparam logic [CNT_W-1:0] TRANSITIONS_RESET = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TRANSITIONS = 2'd1;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    localparam logic [1:0] MODE_CHARGE = 2'd0;
    localparam logic [1:0] MODE_OUTPUT = 2'd1;

    typedef struct packed {
        logic [CNT_W-1:0] half_period;
        logic [CNT_W-1:0] transitions;
    } semc_cfg_t;

    typedef struct packed {
        logic       req_type;
        logic [1:0] op_mode;
        logic       enable_press;
        logic       voltage_valid;
        logic       safety_ok;
    } semc_item_t;

    typedef struct packed {
        logic refresh_event;
        logic enable_requested;
        logic warn_visible;
        logic warn_active;
        logic status_led;
        logic button_led;
        logic converter_enable;
    } semc_result_t;

endpackage

FILE: rtl/core/semc_cfg_regs.sv
// Blink timing configuration registers.
module semc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [semc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [semc_pkg::CNT_W-1:0]         cfg_data,
    output semc_pkg::semc_cfg_t                cfg
);
    import semc_pkg::*;

    semc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period <= HALF_PERIOD_RESET;
            cfg_reg.transitions <= TRANSITIONS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            // drop writes to indexes past the register list
            case (cfg_index)
                CFG_IDX_HALF_PERIOD: cfg_reg.half_period <= cfg_data;
                CFG_IDX_TRANSITIONS: cfg_reg.transitions <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/semc_ctrl_core.sv
// Controller state and its per-request update logic.
module semc_ctrl_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  semc_pkg::semc_item_t       item,
    input  semc_pkg::semc_cfg_t        cfg,
    output semc_pkg::semc_result_t     result
);
    import semc_pkg::*;

    logic             request_reg,  request_next;
    logic             conv_reg,     conv_next;
    logic             warn_on_reg,  warn_on_next;
    logic             phase_reg,    phase_next;
    logic [CNT_W-1:0] ticks_reg,    ticks_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             refresh_reg,  refresh_next;
    logic             btn_led_reg,  btn_led_next;
    logic             stat_led_reg, stat_led_next;
    logic             refresh_out;
    logic [CNT_W-1:0] ticks_inc;
    logic [CNT_W-1:0] count_inc;

    always_comb begin
        request_next  = request_reg;
        conv_next     = conv_reg;
        warn_on_next  = warn_on_reg;
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        count_next    = count_reg;
        refresh_next  = refresh_reg;
        btn_led_next  = btn_led_reg;
        stat_led_next = stat_led_reg;
        refresh_out   = 1'b0;
        ticks_inc     = '0;
        count_inc     = '0;

        if (item.req_type == REQ_TAKE) begin
            refresh_out  = refresh_reg;
            refresh_next = 1'b0;
        end else begin
            unique case (item.op_mode)
                MODE_CHARGE: begin
                    request_next = 1'b0;
                    conv_next    = 1'b0;
                    if (item.enable_press) begin
                        warn_on_next  = 1'b1;
                        phase_next    = 1'b1;
                        ticks_next    = '0;
                        count_next    = '0;
                        refresh_next  = 1'b1;
                        btn_led_next  = 1'b1;
                        stat_led_next = 1'b1;
                    end
                    if (warn_on_next) begin
                        ticks_inc = ticks_next + 1'b1;
                        count_inc = count_next + 1'b1;
                        if (ticks_inc < cfg.half_period) begin
                            ticks_next = ticks_inc;
                        end else begin
                            // half period over: toggle, end after the last transition
                            ticks_next   = '0;
                            refresh_next = 1'b1;
                            if (count_inc >= cfg.transitions) begin
                                warn_on_next  = 1'b0;
                                phase_next    = 1'b1;
                                count_next    = '0;
                                btn_led_next  = 1'b0;
                                stat_led_next = 1'b0;
                            end else begin
                                phase_next    = ~phase_next;
                                count_next    = count_inc;
                                btn_led_next  = phase_next;
                                stat_led_next = phase_next;
                            end
                        end
                    end
                end
                MODE_OUTPUT: begin
                    stat_led_next = 1'b1;
                    warn_on_next  = 1'b0;
                    phase_next    = 1'b1;
                    ticks_next    = '0;
                    count_next    = '0;
                    if (!item.safety_ok) begin
                        request_next = 1'b0;
                        conv_next    = 1'b0;
                        btn_led_next = 1'b0;
                    end else begin
                        if (item.enable_press) begin
                            if (request_reg) begin
                                request_next = 1'b0;
                            end else if (item.voltage_valid) begin
                                request_next = 1'b1;
                            end
                        end
                        if (!item.voltage_valid) begin
                            request_next = 1'b0;
                        end
                        conv_next    = request_next & item.voltage_valid;
                        btn_led_next = conv_next;
                    end
                end
                default: begin
                    request_next  = 1'b0;
                    conv_next     = 1'b0;
                    warn_on_next  = 1'b0;
                    phase_next    = 1'b1;
                    ticks_next    = '0;
                    count_next    = '0;
                    btn_led_next  = 1'b0;
                    stat_led_next = 1'b0;
                end
            endcase
        end

        result.converter_enable = conv_next;
        result.button_led       = btn_led_next;
        result.status_led       = stat_led_next;
        result.warn_active      = warn_on_next;
        result.warn_visible     = phase_next;
        result.enable_requested = request_next;
        result.refresh_event    = refresh_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_reg  <= 1'b0;
            conv_reg     <= 1'b0;
            warn_on_reg  <= 1'b0;
            phase_reg    <= 1'b1;
            ticks_reg    <= '0;
            count_reg    <= '0;
            refresh_reg  <= 1'b0;
            btn_led_reg  <= 1'b0;
            stat_led_reg <= 1'b0;
        end else if (advance) begin
            request_reg  <= request_next;
            conv_reg     <= conv_next;
            warn_on_reg  <= warn_on_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            count_reg    <= count_next;
            refresh_reg  <= refresh_next;
            btn_led_reg  <= btn_led_next;
            stat_led_reg <= stat_led_next;
        end
    end

endmodule

FILE: rtl/core/supply_enable_mode_controller.sv
// Top level: request and result registers around the controller core.
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tuser req_type, s_tdata mode and button fields
//  m_      | out | m_tvalid / m_tready    | m_tdata LED, enable and refresh fields
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (blink timing)
//
// One request per cycle unless m_tready stalls; m_tvalid rises as a result is registered.
// The state update is one pass of logic between the request and result registers.
// aresetn is synchronous; it clears state and both valid flags and resets the blink setup.
// A stalled result holds in its register while the next request waits in the request register.
// cfg_ready is always high.
module supply_enable_mode_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [semc_pkg::S_TDATA_W-1:0]    s_tdata,  // op_mode[1:0], enable_press,
                                                        // voltage_valid, safety_ok, 0[7:5]
    input  logic                              s_tuser,  // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [semc_pkg::M_TDATA_W-1:0]    m_tdata,  // converter_enable, button_led,
                                                        // status_led, warn_active,
                                                        // warn_visible, enable_requested,
                                                        // refresh_event, 0[7]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [semc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [semc_pkg::CNT_W-1:0]        cfg_data
);
    import semc_pkg::*;

    semc_cfg_t    cfg;
    semc_item_t   in_item_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    semc_result_t out_result_reg;
    semc_result_t result;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.req_type      <= s_tuser;
            in_item_reg.op_mode       <= s_tdata[1:0];
            in_item_reg.enable_press  <= s_tdata[2];
            in_item_reg.voltage_valid <= s_tdata[3];
            in_item_reg.safety_ok     <= s_tdata[4];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    semc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    semc_ctrl_core u_ctrl_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

FILE: rtl/core/semc_checker.sv
// Port-level checks for the supply enable mode controller, bound to the top level.
module semc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [semc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import semc_pkg::*;

    // no result right after reset
    a_reset_clears_valid: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // converter runs exactly when the request is latched
    a_conv_matches_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == m_tdata[5])
        else $error("converter enable and request latch disagree");

    // idle warning rests in the visible phase
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[4])
        else $error("warning phase off while warning idle");

    // converter never runs while the charge warning blinks
    a_warn_no_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[0])
        else $error("converter enabled during warning");

endmodule

bind supply_enable_mode_controller semc_checker u_semc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
